### sv/swt_pkg.sv
// Shared types, constants and codes of the sliding window tracker.
package swt_pkg;

	localparam int unsigned CAPACITY_DEF = 8;
	localparam int unsigned MAX_LEN_DEF  = 64;

	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned PAY_W     = 32;
	localparam int unsigned LEN_W     = 7;
	localparam int unsigned CNT_OUT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH    = 3'd0,
		FN_INSERT  = 3'd1,
		FN_ACK     = 3'd2,
		FN_RELEASE = 3'd3,
		FN_CLEAR   = 3'd4
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   packet_id;
		logic [PAY_W-1:0]  payload;
		logic [LEN_W-1:0]  length;
	} in_beat_t;

	typedef struct packed {
		logic                 kind;
		logic                 ok;
		logic [ID_W-1:0]      out_id;
		logic [PAY_W-1:0]     out_payload;
		logic [LEN_W-1:0]     out_length;
		logic [CNT_OUT_W-1:0] count;
		logic [ID_W-1:0]      window_start;
		logic [ID_W-1:0]      next_send_id;
		logic                 last;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAP,
		ST_EXEC,
		ST_REL_CHK,
		ST_REL_OUT,
		ST_STATUS
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic map;
		logic exec;
		logic deliver;
		logic pkt_beat;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rel_go;
		logic head_ready;
	} dp_status_t;

endpackage

### sv/swt_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface swt_in_if;
	import swt_pkg::*;
	logic     valid;
	logic     ready;
	in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface swt_out_if;
	import swt_pkg::*;
	logic      valid;
	logic      ready;
	out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/swt_ctrl.sv
// Controller state machine of the sliding window tracker.
module swt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  swt_pkg::dp_status_t   status,
	output swt_pkg::ctrl_cmd_t    cmd
);
	import swt_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				state_next = ST_MAP;
			end
			ST_MAP: begin
				state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = status.rel_go ? ST_REL_CHK : ST_STATUS;
			end
			ST_REL_CHK: begin
				state_next = status.head_ready ? ST_REL_OUT : ST_STATUS;
			end
			ST_REL_OUT: begin
				if (out_ready) begin
					state_next = ST_REL_CHK;
				end
			end
			ST_STATUS: begin
				if (out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_valid    = (state_q == ST_REL_OUT) || (state_q == ST_STATUS);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.map      = (state_q == ST_MAP);
		cmd.exec     = (state_q == ST_EXEC);
		cmd.deliver  = (state_q == ST_REL_CHK) && status.head_ready;
		cmd.pkt_beat = (state_q == ST_REL_OUT);
	end

endmodule

### sv/swt_dp.sv
// Datapath of the sliding window tracker: slot mapping, slot state and slot memory.
module swt_dp #(
	parameter int unsigned CAPACITY = swt_pkg::CAPACITY_DEF,
	parameter int unsigned MAX_LEN  = swt_pkg::MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swt_pkg::in_beat_t    in_data,
	input  swt_pkg::ctrl_cmd_t   cmd,
	output swt_pkg::dp_status_t  status,
	output swt_pkg::out_beat_t   out_data
);
	import swt_pkg::*;

	localparam int unsigned IDX_W  = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned SHIFT  = ID_W + IDX_W;
	localparam int unsigned RCP_W  = ID_W + 2;
	localparam int unsigned PROD_W = ID_W + RCP_W;
	// Rounded-up reciprocal; exact quotient for every 16-bit offset.
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SHIFT) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));
	localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [IDX_W:0]   CAP_SUM   = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
	localparam logic [ID_W:0]    CAP_WIN   = (ID_W + 1)'(CAPACITY);
	localparam logic [ID_W-1:0]  CAP_ID    = ID_W'(CAPACITY);

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PAY_W-1:0] pay;
		logic [LEN_W-1:0] len;
	} slot_word_t;

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [PAY_W-1:0]  pay_q;
	logic [LEN_W-1:0]  len_q;
	logic [ID_W-1:0]   offset_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  slot_q;

	logic [CAPACITY-1:0] valid_q;
	logic [CAPACITY-1:0] acked_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_W-1:0]     head_q;
	logic [IDX_W-1:0]    hslot_q;
	logic [ID_W-1:0]     tail_q;
	logic                ok_q;

	slot_word_t slot_mem [CAPACITY];
	slot_word_t rd_q;

	logic [LEN_W-1:0]  len_clamped;
	logic [ID_W-1:0]   offset_in;
	logic [PROD_W-1:0] prod_shift;
	logic [ID_W-1:0]   quot;
	logic [ID_W-1:0]   rem;
	logic [IDX_W:0]    slot_sum;
	logic [IDX_W-1:0]  slot_next;
	logic              in_win;
	logic              at_head;
	logic              not_full;
	logic              hit_valid;
	logic              wr_en;
	logic [ID_W-1:0]   wr_id;
	logic [ID_W-1:0]   head_inc;
	logic [IDX_W-1:0]  hslot_inc;

	always_comb begin
		if (32'(in_data.length) > 32'(MAX_LEN)) begin
			len_clamped = LEN_W'(MAX_LEN);
		end else begin
			len_clamped = in_data.length;
		end
	end

	assign offset_in = ((in_data.func == FN_PUSH) ? tail_q : in_data.packet_id) - head_q;

	// Slot of an offset: (head slot + offset mod capacity) mod capacity.
	assign prod_shift = prod_q >> SHIFT;
	assign quot       = prod_shift[ID_W-1:0];
	assign rem        = offset_q - ID_W'(quot * CAP_ID);
	assign slot_sum   = {1'b0, hslot_q} + {1'b0, rem[IDX_W-1:0]};
	assign slot_next  = (slot_sum >= CAP_SUM) ? IDX_W'(slot_sum - CAP_SUM)
	                                          : slot_sum[IDX_W-1:0];

	assign in_win    = ({1'b0, id_q} >= {1'b0, head_q}) &&
	                   ({1'b0, id_q} < ({1'b0, head_q} + CAP_WIN));
	assign at_head   = (id_q == head_q);
	assign not_full  = (count_q < CAP_CNT);
	assign hit_valid = valid_q[slot_q];
	assign wr_id     = (func_q == FN_PUSH) ? tail_q : id_q;
	assign head_inc  = head_q + ID_W'(1);
	assign hslot_inc = (hslot_q == LAST_SLOT) ? '0 : hslot_q + IDX_W'(1);

	always_comb begin
		case (func_q)
			FN_PUSH:   wr_en = not_full;
			FN_INSERT: wr_en = in_win;
			default:   wr_en = 1'b0;
		endcase
	end

	assign status.rel_go     = (func_q == FN_RELEASE) ||
	                           ((func_q == FN_ACK) && in_win && at_head);
	assign status.head_ready = valid_q[hslot_q] && acked_q[hslot_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_data.func;
			id_q     <= in_data.packet_id;
			pay_q    <= in_data.payload;
			len_q    <= len_clamped;
			offset_q <= offset_in;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(offset_q) * PROD_W'(RECIP);
		end
		if (cmd.map) begin
			slot_q <= slot_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acked_q <= '0;
			count_q <= '0;
			head_q  <= '0;
			hslot_q <= '0;
			tail_q  <= '0;
			ok_q    <= 1'b0;
		end else if (cmd.exec) begin
			ok_q <= 1'b0;
			case (func_q)
				FN_PUSH: begin
					if (not_full) begin
						valid_q[slot_q] <= 1'b1;
						acked_q[slot_q] <= 1'b0;
						if (!hit_valid) begin
							count_q <= count_q + CNT_W'(1);
						end
						tail_q <= tail_q + ID_W'(1);
						ok_q   <= 1'b1;
					end
				end
				FN_INSERT: begin
					if (in_win) begin
						valid_q[slot_q] <= 1'b1;
						acked_q[slot_q] <= 1'b1;
						if (!hit_valid) begin
							count_q <= count_q + CNT_W'(1);
						end
						ok_q <= 1'b1;
					end
				end
				FN_ACK: begin
					if (in_win) begin
						if (hit_valid) begin
							acked_q[slot_q] <= 1'b1;
						end
						ok_q <= 1'b1;
					end
				end
				FN_RELEASE: begin
					ok_q <= 1'b1;
				end
				FN_CLEAR: begin
					valid_q <= '0;
					acked_q <= '0;
					count_q <= '0;
					head_q  <= '0;
					hslot_q <= '0;
					tail_q  <= '0;
					ok_q    <= 1'b1;
				end
				default: begin
					ok_q <= 1'b0;
				end
			endcase
		end else if (cmd.deliver) begin
			valid_q[hslot_q] <= 1'b0;
			acked_q[hslot_q] <= 1'b0;
			count_q          <= count_q - CNT_W'(1);
			head_q           <= head_inc;
			hslot_q          <= hslot_inc;
			if (tail_q < head_inc) begin
				tail_q <= head_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			slot_mem[slot_q] <= '{id: wr_id, pay: pay_q, len: len_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			rd_q <= slot_mem[hslot_q];
		end
	end

	always_comb begin
		out_data.kind         = cmd.pkt_beat;
		out_data.ok           = cmd.pkt_beat ? 1'b1 : ok_q;
		out_data.out_id       = cmd.pkt_beat ? rd_q.id : '0;
		out_data.out_payload  = cmd.pkt_beat ? rd_q.pay : '0;
		out_data.out_length   = cmd.pkt_beat ? rd_q.len : '0;
		out_data.count        = CNT_OUT_W'(32'(count_q));
		out_data.window_start = head_q;
		out_data.next_send_id = tail_q;
		out_data.last         = !cmd.pkt_beat;
	end

endmodule

### sv/sliding_window_tracker.sv
// Top level of the selective-repeat sliding window tracker.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       func, packet_id, payload, length
//   out_ch   source     kind, ok, out_id, out_payload, out_length, count,
//                       window_start, next_send_id, last
//
// One item is worked on at a time. After a beat is accepted on in_ch, the
// slot index is found by a reciprocal multiply and a correction, and the
// slot is then updated. An ack of the head or a release then checks the
// head before each delivered packet and once more to find the head not
// ready; each delivered packet is a head check with a read of the slot
// memory and then the beat on out_ch. The closing status beat follows.
// Reset clears all slot flags, the window and the send id at once; a
// stalled out_ch holds its beat and the block takes no input until the
// status beat has gone.
module sliding_window_tracker #(
	parameter int unsigned CAPACITY = swt_pkg::CAPACITY_DEF,
	parameter int unsigned MAX_LEN  = swt_pkg::MAX_LEN_DEF
) (
	input logic      clk,
	input logic      arst_n,
	swt_in_if.sink   in_ch,
	swt_out_if.source out_ch
);
	import swt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The controller sequences the handshakes and the slot-mapping steps.
	swt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the window state, the slot memory and the result beat.
	swt_dp #(
		.CAPACITY (CAPACITY),
		.MAX_LEN  (MAX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_ch.data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_ch.data)
	);

	// No new input is taken while a result beat is offered.
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while a result beat is pending");

	// The slot mapping takes time, so no beat follows an accept directly.
	a_no_out_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !out_ch.valid)
		else $error("result beat directly after input accept");

	// Each delivery advances the window start by exactly one.
	a_deliver_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |=> (out_ch.data.window_start ==
			$past(out_ch.data.window_start) + 16'd1))
		else $error("window did not advance on delivery");

	// A delivered packet beat is always accepted and never the final beat.
	a_pkt_beat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.kind) |-> (out_ch.data.ok && !out_ch.data.last))
		else $error("malformed delivered packet beat");

endmodule
